@@ hw/rtl/cpsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsa_pkg
// Shared types, constants and the arctangent table for the phase sector
// activation pipeline.
// ----------------------------------------------------------------------------
package cpsa_pkg;

    localparam int DW = 44;
    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_EIGHTH  = 32'h2000_0000;
    localparam logic signed [DW-1:0] INV_GAIN = DW'(652032874);

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_COUNT = 2'd1,
        CFG_STEP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic [31:0]          z;
        logic [1:0]           quad;
        logic [7:0]           sector;
        logic                 bad;
        logic                 hold;
    } t_data;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h2000_0000;
            1:  r = 32'h12E4_051E;
            2:  r = 32'h09FB_385B;
            3:  r = 32'h0511_11D4;
            4:  r = 32'h028B_0D43;
            5:  r = 32'h0145_D7E1;
            6:  r = 32'h00A2_F61E;
            7:  r = 32'h0051_7C55;
            8:  r = 32'h0028_BE53;
            9:  r = 32'h0014_5F2F;
            10: r = 32'h000A_2F98;
            11: r = 32'h0005_17CC;
            12: r = 32'h0002_8BE6;
            13: r = 32'h0001_45F3;
            14: r = 32'h0000_A2FA;
            15: r = 32'h0000_517D;
            16: r = 32'h0000_28BE;
            17: r = 32'h0000_145F;
            18: r = 32'h0000_0A30;
            19: r = 32'h0000_0518;
            20: r = 32'h0000_028C;
            21: r = 32'h0000_0146;
            22: r = 32'h0000_00A3;
            23: r = 32'h0000_0051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/cpsa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsa_in_if
// Input channel: one complex weighted sum per transaction.
// ----------------------------------------------------------------------------
interface cpsa_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;

    modport source (output valid, output z_real, output z_imag, input ready);
    modport sink   (input valid, input z_real, input z_imag, output ready);
endinterface

@@ hw/rtl/cpsa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsa_out_if
// Output channel: one activation result per transaction.
// ----------------------------------------------------------------------------
interface cpsa_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] phi_real;
    logic signed [15:0] phi_imag;
    logic [7:0]         sector_index;
    logic               bad_value;

    modport source (output valid, output phi_real, output phi_imag,
                    output sector_index, output bad_value, input ready);
    modport sink   (input valid, input phi_real, input phi_imag,
                    input sector_index, input bad_value, output ready);
endinterface

@@ hw/rtl/complex_phase_sector_activation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_phase_sector_activation
// Multi-valued neuron activation: z/|z| or the unit point of the phase sector.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  i_in     | sink      | z_real, z_imag (Q16.16)
//  o_out    | source    | phi_real, phi_imag (Q1.14), sector_index, bad_value
//  i_cfg_*  | write     | continuous_mode, sector_count, sector_step
//
//  Stages in order: normalize, vectoring, phase, angle, quadrant, rotation, output.
//  One transaction per cycle is accepted and delivered when not stalled.
//  Every stage holds its own valid bit; a stall fills bubbles and drops nothing.
//  Synchronous active-low reset clears valid bits and restores config defaults.
// ----------------------------------------------------------------------------
module complex_phase_sector_activation #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int MAX_SECTORS   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    cpsa_in_if.sink     i_in,
    cpsa_out_if.source  o_out
);
    localparam int AB = ANGLE_BITS;
    localparam int N  = CORDIC_STAGES;
    localparam int CW = $clog2(MAX_SECTORS + 1);
    localparam int DW = cpsa_pkg::DW;

    logic        r_cfg_mode;
    logic [8:0]  r_cfg_count;
    logic [16:0] r_cfg_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode  <= 1'b0;
            r_cfg_count <= 9'd8;
            r_cfg_step  <= 17'd8192;
        end else if (i_cfg_we) begin
            unique case (cpsa_pkg::t_cfg_idx'(i_cfg_index))
                cpsa_pkg::CFG_MODE:  r_cfg_mode  <= i_cfg_data[0];
                cpsa_pkg::CFG_COUNT: r_cfg_count <= i_cfg_data[8:0];
                cpsa_pkg::CFG_STEP:  r_cfg_step  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: normalize
    logic            r_s0_v;
    cpsa_pkg::t_data r_s0_d;
    cpsa_pkg::t_data n_s0_d;
    logic            s0_en;

    logic            vec_v   [0:N];
    logic            vec_rdy [0:N];
    cpsa_pkg::t_data vec_d   [0:N];

    always_comb begin
        logic signed [31:0]    xi;
        logic signed [31:0]    yi;
        logic [32:0]           ax;
        logic [32:0]           ay;
        logic [32:0]           m;
        logic [5:0]            pos;
        logic [5:0]            sh;
        logic signed [DW-1:0]  xs;
        logic signed [DW-1:0]  ys;
        xi = i_in.z_real;
        yi = i_in.z_imag;
        ax = xi[31] ? -{xi[31], xi} : {xi[31], xi};
        ay = yi[31] ? -{yi[31], yi} : {yi[31], yi};
        m  = (ax > ay) ? ax : ay;
        pos = 6'd0;
        for (int k = 0; k < 33; k++) begin
            if (m[k]) begin
                pos = 6'(k);
            end
        end
        sh = 6'd39 - pos;
        xs = DW'(xi) <<< sh;
        ys = DW'(yi) <<< sh;
        n_s0_d        = '0;
        n_s0_d.bad    = r_cfg_mode && (xi == 32'sd0) && (yi == 32'sd0);
        n_s0_d.x      = xs;
        n_s0_d.y      = ys;
        if (yi == 32'sd0) begin
            n_s0_d.hold = 1'b1;
            n_s0_d.z    = xi[31] ? cpsa_pkg::TURN_HALF : 32'h0;
        end else if (xi == 32'sd0) begin
            n_s0_d.hold = 1'b1;
            n_s0_d.z    = yi[31] ? (cpsa_pkg::TURN_HALF | cpsa_pkg::TURN_QUARTER)
                                 : cpsa_pkg::TURN_QUARTER;
        end else if (xi[31]) begin
            n_s0_d.x = -xs;
            n_s0_d.y = -ys;
            n_s0_d.z = cpsa_pkg::TURN_HALF;
        end
    end

    assign s0_en      = !r_s0_v || vec_rdy[0];
    assign i_in.ready = s0_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (s0_en) begin
            r_s0_v <= i_in.valid;
        end
        if (s0_en && i_in.valid) begin
            r_s0_d <= n_s0_d;
        end
    end

    assign vec_v[0] = r_s0_v;
    assign vec_d[0] = r_s0_d;

    // phase register stage signals
    logic            r_ph_v;
    cpsa_pkg::t_data r_ph_d;
    logic [CW-1:0]   r_ph_sector;
    logic            ph_en;

    generate
        for (genvar g = 0; g < N; g++) begin : g_vec
            cpsa_cordic_stage #(.IDX(g), .ROTATE(1'b0)) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (vec_v[g]),
                .o_ready (vec_rdy[g]),
                .i_data  (vec_d[g]),
                .o_valid (vec_v[g+1]),
                .i_ready (vec_rdy[g+1]),
                .o_data  (vec_d[g+1])
            );
        end
    endgenerate

    // sector from phase
    logic                 ang_rdy;
    cpsa_pkg::t_data      n_ph_d;
    logic [CW-1:0]        n_ph_sector;

    always_comb begin
        logic [31:0]      rsum;
        logic [AB-1:0]    phase;
        logic [CW-1:0]    cnt;
        logic [AB+CW-1:0] prod;
        rsum = vec_d[N].z + (32'h1 << (31 - AB));
        phase = rsum[31 -: AB];
        if (r_cfg_count == 9'd0) begin
            cnt = CW'(1);
        end else if (32'(r_cfg_count) > 32'(MAX_SECTORS)) begin
            cnt = CW'(MAX_SECTORS);
        end else begin
            cnt = CW'(r_cfg_count);
        end
        prod        = (AB+CW)'(phase) * (AB+CW)'(cnt);
        n_ph_sector = CW'(prod >> AB);
        n_ph_d        = vec_d[N];
        n_ph_d.sector = 8'(n_ph_sector);
    end

    assign vec_rdy[N] = ph_en;
    assign ph_en      = !r_ph_v || ang_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_v <= 1'b0;
        end else if (ph_en) begin
            r_ph_v <= vec_v[N];
        end
        if (ph_en && vec_v[N]) begin
            r_ph_d      <= n_ph_d;
            r_ph_sector <= n_ph_sector;
        end
    end

    // angle
    logic            r_ang_v;
    cpsa_pkg::t_data r_ang_d;
    logic            q_rdy;
    cpsa_pkg::t_data n_ang_d;

    always_comb begin
        logic [CW+16:0] aprod;
        logic [AB-1:0]  ang;
        aprod = (CW+17)'(r_ph_sector) * (CW+17)'(r_cfg_step);
        ang   = aprod[AB-1:0];
        n_ang_d = r_ph_d;
        if (!r_cfg_mode) begin
            n_ang_d.z = {ang, {(32-AB){1'b0}}};
        end
    end

    assign ang_rdy = !r_ang_v || q_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_v <= 1'b0;
        end else if (ang_rdy) begin
            r_ang_v <= r_ph_v;
        end
        if (ang_rdy && r_ph_v) begin
            r_ang_d <= n_ang_d;
        end
    end

    // quadrant fold, rotation seed
    logic            rot_v   [0:N];
    logic            rot_rdy [0:N];
    cpsa_pkg::t_data rot_d   [0:N];
    logic            r_q_v;
    cpsa_pkg::t_data r_q_d;
    cpsa_pkg::t_data n_q_d;

    always_comb begin
        logic [31:0] qs;
        qs = r_ang_d.z + cpsa_pkg::TURN_EIGHTH;
        n_q_d      = r_ang_d;
        n_q_d.quad = qs[31:30];
        n_q_d.z    = r_ang_d.z - {qs[31:30], 30'h0};
        n_q_d.x    = cpsa_pkg::INV_GAIN;
        n_q_d.y    = '0;
    end

    assign q_rdy = !r_q_v || rot_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (q_rdy) begin
            r_q_v <= r_ang_v;
        end
        if (q_rdy && r_ang_v) begin
            r_q_d <= n_q_d;
        end
    end

    assign rot_v[0] = r_q_v;
    assign rot_d[0] = r_q_d;

    generate
        for (genvar g = 0; g < N; g++) begin : g_rot
            cpsa_cordic_stage #(.IDX(g), .ROTATE(1'b1)) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (rot_v[g]),
                .o_ready (rot_rdy[g]),
                .i_data  (rot_d[g]),
                .o_valid (rot_v[g+1]),
                .i_ready (rot_rdy[g+1]),
                .o_data  (rot_d[g+1])
            );
        end
    endgenerate

    // output register
    logic               r_out_v;
    logic signed [15:0] r_out_re;
    logic signed [15:0] r_out_im;
    logic [7:0]         r_out_sec;
    logic               r_out_bad;
    logic signed [15:0] n_out_re;
    logic signed [15:0] n_out_im;
    logic               out_en;

    function automatic logic signed [15:0] to_q14(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = (v + DW'(32768)) >>> 16;
        if (r > DW'(16384)) begin
            r = DW'(16384);
        end else if (r < -DW'(16384)) begin
            r = -DW'(16384);
        end
        return 16'(r);
    endfunction

    always_comb begin
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        cx = to_q14(rot_d[N].x);
        cy = to_q14(rot_d[N].y);
        case (rot_d[N].quad)
            2'd0:    begin n_out_re = cx;  n_out_im = cy;  end
            2'd1:    begin n_out_re = -cy; n_out_im = cx;  end
            2'd2:    begin n_out_re = -cx; n_out_im = -cy; end
            default: begin n_out_re = cy;  n_out_im = -cx; end
        endcase
        if (rot_d[N].bad) begin
            n_out_re = '0;
            n_out_im = '0;
        end
    end

    assign out_en     = !r_out_v || o_out.ready;
    assign rot_rdy[N] = out_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_en) begin
            r_out_v <= rot_v[N];
        end
        if (out_en && rot_v[N]) begin
            r_out_re  <= n_out_re;
            r_out_im  <= n_out_im;
            r_out_sec <= r_cfg_mode ? 8'd0 : rot_d[N].sector;
            r_out_bad <= rot_d[N].bad;
        end
    end

    assign o_out.valid        = r_out_v;
    assign o_out.phi_real     = r_out_re;
    assign o_out.phi_imag     = r_out_im;
    assign o_out.sector_index = r_out_sec;
    assign o_out.bad_value    = r_out_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_bad |-> r_out_re == 16'sd0 && r_out_im == 16'sd0)
        else $error("bad result carries nonzero phi");
    a_bad_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_bad |-> r_cfg_mode)
        else $error("bad result outside continuous mode");
    a_sec_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_cfg_mode |-> r_out_sec == 8'd0)
        else $error("sector nonzero in continuous mode");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s0_v |-> i_in.ready)
        else $error("empty entry stage not ready");
endmodule

@@ hw/rtl/cpsa_cordic_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsa_cordic_stage
// One registered CORDIC micro-rotation, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module cpsa_cordic_stage #(
    parameter int IDX    = 0,
    parameter bit ROTATE = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cpsa_pkg::t_data i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cpsa_pkg::t_data o_data
);
    logic            r_valid;
    cpsa_pkg::t_data r_data;
    cpsa_pkg::t_data n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        logic signed [cpsa_pkg::DW-1:0] dx;
        logic signed [cpsa_pkg::DW-1:0] dy;
        logic                           pos;
        dx = i_data.y >>> IDX;
        dy = i_data.x >>> IDX;
        n_data = i_data;
        pos = 1'b0;
        if (ROTATE) begin
            pos = !i_data.z[31];
            if (pos) begin
                n_data.x = i_data.x - dx;
                n_data.y = i_data.y + dy;
                n_data.z = i_data.z - cpsa_pkg::atan_turn(IDX);
            end else begin
                n_data.x = i_data.x + dx;
                n_data.y = i_data.y - dy;
                n_data.z = i_data.z + cpsa_pkg::atan_turn(IDX);
            end
        end else if (!i_data.hold) begin
            pos = !i_data.y[cpsa_pkg::DW-1];
            if (pos) begin
                n_data.x = i_data.x + dx;
                n_data.y = i_data.y - dy;
                n_data.z = i_data.z + cpsa_pkg::atan_turn(IDX);
            end else begin
                n_data.x = i_data.x - dx;
                n_data.y = i_data.y + dy;
                n_data.z = i_data.z - cpsa_pkg::atan_turn(IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

@@ test/cpsa_activation_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsa_activation_checker
// Watches the input and output channels and the register write port of the
// phase sector activation block. Every input transaction gets its expected
// activation from a bit-exact CORDIC model. Each output transaction is
// checked field by field against the oldest expected activation.
// ----------------------------------------------------------------------------
module cpsa_activation_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    cpsa_in_if          i_in,
    cpsa_out_if         i_out,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef struct {
        logic signed [15:0] phi_real;
        logic signed [15:0] phi_imag;
        logic [7:0]         sector_index;
        logic               bad_value;
    } t_activation;

    t_activation expected_q[$];
    logic        mode_cont;
    logic [8:0]  n_sectors;
    logic [16:0] sector_turn;

    function automatic logic [31:0] arctan_step(input int i);
        logic [31:0] t [16] = '{
            32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
            32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
            32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
            32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D};
        return t[i];
    endfunction

    function automatic logic [31:0] phase_of(input longint x, input longint y);
        longint      ax, ay, m, dx, dy;
        logic [31:0] acc;
        acc = '0;
        if (y == 0) return (x < 0) ? cpsa_pkg::TURN_HALF : 32'd0;
        if (x == 0) return (y > 0) ? cpsa_pkg::TURN_QUARTER
                                   : (cpsa_pkg::TURN_HALF | cpsa_pkg::TURN_QUARTER);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        while (m < (64'sd1 <<< 39)) begin
            m = m <<< 1;
            x = x <<< 1;
            y = y <<< 1;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = cpsa_pkg::TURN_HALF;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += arctan_step(i);
            end else begin
                x -= dx; y += dy; acc -= arctan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint round_q14(input longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic void rotate_unit(input logic [31:0] ang,
                                        output longint re, output longint im);
        logic [31:0] q, ur;
        longint      z, x, y, dx, dy, cx, cy;
        q  = ((ang + cpsa_pkg::TURN_EIGHTH) >> 30) & 32'd3;
        ur = ang - (q << 30);
        z  = longint'(int'(ur));
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(arctan_step(i));
            end else begin
                x += dx; y -= dy; z += longint'(arctan_step(i));
            end
        end
        cx = round_q14(x);
        cy = round_q14(y);
        case (q)
            0: begin re = cx;  im = cy;  end
            1: begin re = -cy; im = cx;  end
            2: begin re = -cx; im = -cy; end
            default: begin re = cy; im = -cx; end
        endcase
    endfunction

    function automatic t_activation activate(input logic signed [31:0] zr,
                                             input logic signed [31:0] zi);
        t_activation a;
        longint      x, y, re, im;
        logic [31:0] acc;
        logic [63:0] cnt, ph, sec, ang;
        x = zr;
        y = zi;
        re = 0;
        im = 0;
        sec = 0;
        a.bad_value = 1'b0;
        acc = phase_of(x, y);
        if (mode_cont) begin
            if (x == 0 && y == 0) a.bad_value = 1'b1;
            else rotate_unit(acc, re, im);
        end else begin
            cnt = n_sectors;
            if (cnt == 0) cnt = 1;
            if (cnt > 256) cnt = 256;
            ph  = (({32'd0, acc} + 64'd32768) >> 16) & 64'hFFFF;
            sec = (ph * cnt) >> 16;
            ang = (sec * {47'd0, sector_turn}) & 64'hFFFF;
            rotate_unit({ang[15:0], 16'd0}, re, im);
        end
        a.phi_real     = re[15:0];
        a.phi_imag     = im[15:0];
        a.sector_index = sec[7:0];
        return a;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_activation e;
        int          nerr;
        nerr = 0;
        if (!i_rst_n) begin
            mode_cont   <= 1'b0;
            n_sectors   <= 9'd8;
            sector_turn <= 17'd8192;
            o_errors    <= 0;
            o_results   <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cpsa_pkg::CFG_MODE:  mode_cont   <= i_cfg_data[0];
                    cpsa_pkg::CFG_COUNT: n_sectors   <= i_cfg_data[8:0];
                    cpsa_pkg::CFG_STEP:  sector_turn <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(activate(i_in.z_real, i_in.z_imag));
            if (i_out.valid && i_out.ready) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected activation transaction");
                    nerr++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.phi_real !== i_out.phi_real) begin
                        $error("phi_real expected %0d actual %0d", e.phi_real,
                               i_out.phi_real);
                        nerr++;
                    end
                    if (e.phi_imag !== i_out.phi_imag) begin
                        $error("phi_imag expected %0d actual %0d", e.phi_imag,
                               i_out.phi_imag);
                        nerr++;
                    end
                    if (e.sector_index !== i_out.sector_index) begin
                        $error("sector_index expected %0d actual %0d",
                               e.sector_index, i_out.sector_index);
                        nerr++;
                    end
                    if (e.bad_value !== i_out.bad_value) begin
                        $error("bad_value expected %0d actual %0d", e.bad_value,
                               i_out.bad_value);
                        nerr++;
                    end
                end
            end
            o_errors <= o_errors + nerr;
        end
    end

endmodule

@@ test/tb_complex_phase_sector_activation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_phase_sector_activation
// Drives directed and random weighted sums through the activation block
// under several register settings, with random gaps on both channels, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_complex_phase_sector_activation;

    localparam int LATENCY   = 2 * 16 + 5;
    localparam int WATCH_MAX = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    logic        calm;
    int          stall_left;
    int          idle_cycles;
    int          n_sent;
    int          n_settings;
    int          errors, pending, results;

    cpsa_in_if  in_ch ();
    cpsa_out_if out_ch ();

    complex_phase_sector_activation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    cpsa_activation_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            int g;
            g = pick_gap();
            out_ch.ready <= (g == 0);
            stall_left   <= (g > 0) ? g - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_sum(input logic [31:0] zr, input logic [31:0] zi);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.z_real <= zr;
        in_ch.z_imag <= zi;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_reg(input cpsa_pkg::t_cfg_idx idx, input logic [16:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setting(input logic m, input logic [16:0] cnt, input logic [16:0] stp);
        write_reg(cpsa_pkg::CFG_MODE, {16'd0, m});
        write_reg(cpsa_pkg::CFG_COUNT, cnt);
        write_reg(cpsa_pkg::CFG_STEP, stp);
        n_settings++;
    endtask

    function automatic logic [31:0] rand_part();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom();
        if (r < 75) return $urandom() >> $urandom_range(8, 30);
        if (r < 85) return -($urandom() >> $urandom_range(8, 30));
        if (r < 92) return 32'd0;
        return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    task automatic random_batch(input int n);
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            calm = ($urandom_range(0, 9) == 0);
            a = rand_part();
            if ($urandom_range(0, 4) == 0)
                send_sum(a, $urandom_range(0, 1) ? a : -a);
            else
                send_sum(a, rand_part());
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [31:0] edge_vals [10] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001,
            32'h0000_8000, 32'h5555_AAAA};
        in_ch.valid  <= 1'b0;
        in_ch.z_real <= '0;
        in_ch.z_imag <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= cpsa_pkg::CFG_MODE;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        calm         = 1'b0;
        n_sent       = 0;
        n_settings   = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 10; k++) send_sum(edge_vals[k], 32'd0);
        for (int k = 0; k < 10; k++) send_sum(32'd0, edge_vals[k]);
        send_sum(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sum(32'h8000_0000, 32'h8000_0000);
        send_sum(32'hFFFF_FFFF, 32'h0000_0001);
        random_batch(60);
        drain();

        setting(1'b1, 17'd8, 17'd8192);
        send_sum(32'd0, 32'd0);
        send_sum(32'h8000_0000, 32'h7FFF_FFFF);
        random_batch(80);
        drain();

        setting(1'b0, 17'd1, 17'd65536);
        random_batch(60);
        drain();
        setting(1'b0, 17'd256, 17'd256);
        random_batch(80);
        drain();
        setting(1'b0, 17'd0, 17'd0);
        random_batch(50);
        drain();
        setting(1'b0, 17'h1FFFF, 17'd1);
        write_reg(cpsa_pkg::t_cfg_idx'(2'd3), 17'h1FFFF);
        random_batch(70);
        drain();
        setting(1'b0, 17'd3, 17'd21845);
        random_batch(70);
        drain();
        setting(1'b0, 17'd100, 17'h1FFFF);
        random_batch(60);
        drain();
        setting(1'b1, 17'd5, 17'd13107);
        random_batch(60);
        drain();

        $display("covered %0d sums and %0d results over %0d register settings",
                 n_sent, results, n_settings);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
